// ===== hdl/websocket_frame_parser_assert.svh =====
// assertion macros shared by the frame parser
`ifndef WEBSOCKET_FRAME_PARSER_ASSERT_SVH
`define WEBSOCKET_FRAME_PARSER_ASSERT_SVH

// same-cycle implication, disabled while reset is low
`define WSFP_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is low
`define WSFP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/wsfp_pkg.sv =====
// types, codes and helpers for the websocket frame parser
package wsfp_pkg;

    typedef enum logic [4:0] {
        PH_HDR0    = 5'b00001,
        PH_HDR1    = 5'b00010,
        PH_EXTLEN  = 5'b00100,
        PH_MASK    = 5'b01000,
        PH_PAYLOAD = 5'b10000
    } t_phase;

    localparam logic [3:0] OP_CONT  = 4'h0;
    localparam logic [3:0] OP_TEXT  = 4'h1;
    localparam logic [3:0] OP_BIN   = 4'h2;
    localparam logic [3:0] OP_PING  = 4'h9;
    localparam logic [3:0] OP_PONG  = 4'hA;

    localparam logic [2:0] KIND_TEXT      = 3'd0;
    localparam logic [2:0] KIND_TEXT_FRAG = 3'd1;
    localparam logic [2:0] KIND_BIN       = 3'd2;
    localparam logic [2:0] KIND_BIN_FRAG  = 3'd3;
    localparam logic [2:0] KIND_PING      = 3'd4;
    localparam logic [2:0] KIND_PONG      = 3'd5;
    localparam logic [2:0] KIND_ERROR     = 3'd6;

    localparam logic [6:0] LEN7_MAX_SHORT = 7'd125;
    localparam logic [6:0] LEN7_EXT16     = 7'd126;
    localparam logic [3:0] EXT16_BYTES    = 4'd2;
    localparam logic [3:0] EXT64_BYTES    = 4'd8;
    localparam logic [3:0] KEY_BYTES      = 4'd4;

    typedef struct packed {
        logic       valid;
        logic [7:0] payload_byte;
        logic       has_byte;
        logic       frame_end;
        logic [2:0] frame_kind;
    } t_result;

    function automatic logic [2:0] frame_kind_of(input logic [3:0] opcode, input logic fin);
        logic [2:0] kind;
        case (opcode)
            OP_CONT, OP_TEXT: kind = fin ? KIND_TEXT : KIND_TEXT_FRAG;
            OP_BIN:           kind = fin ? KIND_BIN : KIND_BIN_FRAG;
            OP_PING:          kind = KIND_PING;
            OP_PONG:          kind = KIND_PONG;
            default:          kind = KIND_ERROR;
        endcase
        return kind;
    endfunction

endpackage

// ===== hdl/wsfp_deframer.sv =====
// header/payload state machine with unmasking, one byte per step
module wsfp_deframer (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_step,
    input  logic [7:0]          i_byte,
    output wsfp_pkg::t_result   o_res
);

    wsfp_pkg::t_phase r_phase, n_phase;
    logic [3:0]  r_left, n_left;
    logic [63:0] r_payload_left, n_payload_left;
    logic [31:0] r_key, n_key;
    logic [1:0]  r_key_idx, n_key_idx;
    logic [3:0]  r_opcode, n_opcode;
    logic        r_fin, n_fin;
    logic        r_masked, n_masked;

    logic [3:0]  w_left_dec;
    logic [63:0] w_len_new;
    logic [7:0]  w_key_byte;

    assign w_left_dec = r_left - 4'd1;

    always_comb begin
        case (r_key_idx)
            2'd0:    w_key_byte = r_key[31:24];
            2'd1:    w_key_byte = r_key[23:16];
            2'd2:    w_key_byte = r_key[15:8];
            default: w_key_byte = r_key[7:0];
        endcase
    end

    always_comb begin
        n_phase        = r_phase;
        n_left         = r_left;
        n_payload_left = r_payload_left;
        n_key          = r_key;
        n_key_idx      = r_key_idx;
        n_opcode       = r_opcode;
        n_fin          = r_fin;
        n_masked       = r_masked;
        w_len_new      = '0;
        o_res          = '0;
        case (r_phase)
            wsfp_pkg::PH_HDR1: begin
                n_masked = i_byte[7];
                if (i_byte[6:0] <= wsfp_pkg::LEN7_MAX_SHORT) begin
                    w_len_new      = {57'd0, i_byte[6:0]};
                    n_payload_left = w_len_new;
                    n_key_idx      = 2'd0;
                    if (i_byte[7]) begin
                        n_phase = wsfp_pkg::PH_MASK;
                        n_left  = wsfp_pkg::KEY_BYTES;
                    end else if (i_byte[6:0] == 7'd0) begin
                        // empty unmasked frame closes here
                        n_phase = wsfp_pkg::PH_HDR0;
                        o_res.valid     = 1'b1;
                        o_res.frame_end = 1'b1;
                    end else begin
                        n_phase = wsfp_pkg::PH_PAYLOAD;
                    end
                end else begin
                    n_payload_left = '0;
                    n_phase        = wsfp_pkg::PH_EXTLEN;
                    n_left         = (i_byte[6:0] == wsfp_pkg::LEN7_EXT16)
                                     ? wsfp_pkg::EXT16_BYTES : wsfp_pkg::EXT64_BYTES;
                end
            end
            wsfp_pkg::PH_EXTLEN: begin
                w_len_new      = {r_payload_left[55:0], i_byte};
                n_payload_left = w_len_new;
                n_left         = w_left_dec;
                if (w_left_dec == 4'd0) begin
                    n_key_idx = 2'd0;
                    if (r_masked) begin
                        n_phase = wsfp_pkg::PH_MASK;
                        n_left  = wsfp_pkg::KEY_BYTES;
                    end else if (w_len_new == 64'd0) begin
                        n_phase = wsfp_pkg::PH_HDR0;
                        o_res.valid     = 1'b1;
                        o_res.frame_end = 1'b1;
                    end else begin
                        n_phase = wsfp_pkg::PH_PAYLOAD;
                    end
                end
            end
            wsfp_pkg::PH_MASK: begin
                n_key  = {r_key[23:0], i_byte};
                n_left = w_left_dec;
                if (w_left_dec == 4'd0) begin
                    n_key_idx = 2'd0;
                    if (r_payload_left == 64'd0) begin
                        n_phase = wsfp_pkg::PH_HDR0;
                        o_res.valid     = 1'b1;
                        o_res.frame_end = 1'b1;
                    end else begin
                        n_phase = wsfp_pkg::PH_PAYLOAD;
                    end
                end
            end
            wsfp_pkg::PH_PAYLOAD: begin
                n_key_idx      = r_key_idx + 2'd1;
                n_payload_left = r_payload_left - 64'd1;
                o_res.valid        = 1'b1;
                o_res.has_byte     = 1'b1;
                o_res.payload_byte = r_masked ? (i_byte ^ w_key_byte) : i_byte;
                // last byte when one was left before this beat
                if (r_payload_left == 64'd1) begin
                    n_phase = wsfp_pkg::PH_HDR0;
                    o_res.frame_end = 1'b1;
                end
            end
            default: begin
                n_fin    = i_byte[7];
                n_opcode = i_byte[3:0];
                n_phase  = wsfp_pkg::PH_HDR1;
            end
        endcase
        if (o_res.frame_end) begin
            o_res.frame_kind = wsfp_pkg::frame_kind_of(r_opcode, r_fin);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase        <= wsfp_pkg::PH_HDR0;
            r_left         <= '0;
            r_payload_left <= '0;
            r_key          <= '0;
            r_key_idx      <= '0;
            r_opcode       <= '0;
            r_fin          <= 1'b0;
            r_masked       <= 1'b0;
        end else if (i_step) begin
            r_phase        <= n_phase;
            r_left         <= n_left;
            r_payload_left <= n_payload_left;
            r_key          <= n_key;
            r_key_idx      <= n_key_idx;
            r_opcode       <= n_opcode;
            r_fin          <= n_fin;
            r_masked       <= n_masked;
        end
    end

endmodule

// ===== hdl/wsfp_out_reg.sv =====
// result register on the output channel
module wsfp_out_reg (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_load,
    input  wsfp_pkg::t_result   i_res,
    input  logic                i_ready,
    output logic                o_valid,
    output logic [7:0]          o_payload_byte,
    output logic                o_has_byte,
    output logic                o_frame_end,
    output logic [2:0]          o_frame_kind
);

    logic       r_valid;
    logic [7:0] r_payload_byte;
    logic       r_has_byte;
    logic       r_frame_end;
    logic [2:0] r_frame_kind;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load && i_res.valid) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    // load only happens when the register is empty or being drained
    always_ff @(posedge i_clk) begin
        if (i_load && i_res.valid) begin
            r_payload_byte <= i_res.payload_byte;
            r_has_byte     <= i_res.has_byte;
            r_frame_end    <= i_res.frame_end;
            r_frame_kind   <= i_res.frame_kind;
        end
    end

    assign o_valid        = r_valid;
    assign o_payload_byte = r_payload_byte;
    assign o_has_byte     = r_has_byte;
    assign o_frame_end    = r_frame_end;
    assign o_frame_kind   = r_frame_kind;

endmodule

// ===== hdl/websocket_frame_parser.sv =====
// websocket frame parser: received byte stream in, unmasked payload beats out
// an accepted byte waits in the input register until the result register can take its result
// throughput: one byte per cycle while the output is not stalled, set by the combinational
// parse between the input register and the result register
// reset: synchronous active low, returns to expecting a first header byte and
// empties both registers
`include "websocket_frame_parser_assert.svh"
module websocket_frame_parser (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [7:0] i_rx_byte,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [7:0] o_payload_byte,
    output logic       o_has_byte,
    output logic       o_frame_end,
    output logic [2:0] o_frame_kind
);

    logic              r_in_valid;
    logic [7:0]        r_in_byte;
    logic              w_step;
    wsfp_pkg::t_result w_res;

    // the held byte moves on whenever the result register can take it
    assign w_step     = r_in_valid && (!o_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || w_step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in_valid && o_in_ready) begin
            r_in_valid <= 1'b1;
        end else if (w_step) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in_byte <= i_rx_byte;
        end
    end

    wsfp_deframer u_deframer (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (w_step),
        .i_byte  (r_in_byte),
        .o_res   (w_res)
    );

    wsfp_out_reg u_out_reg (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_load         (w_step),
        .i_res          (w_res),
        .i_ready        (i_out_ready),
        .o_valid        (o_out_valid),
        .o_payload_byte (o_payload_byte),
        .o_has_byte     (o_has_byte),
        .o_frame_end    (o_frame_end),
        .o_frame_kind   (o_frame_kind)
    );

    `WSFP_ASSERT_IMPLY(a_empty_is_end, i_clk, i_rst_n, o_out_valid && !o_has_byte, o_frame_end, "empty result without frame end")
    `WSFP_ASSERT_IMPLY(a_kind_zero, i_clk, i_rst_n, o_out_valid && !o_frame_end, o_frame_kind == 3'd0, "kind set before frame end")
    `WSFP_ASSERT_IMPLY(a_data_zero, i_clk, i_rst_n, o_out_valid && !o_has_byte, o_payload_byte == 8'd0, "data on empty result")
    `WSFP_ASSERT_IMPLY(a_ready_when_empty, i_clk, i_rst_n, !o_out_valid, o_in_ready, "input stalled with output empty")
    `WSFP_ASSERT_NEXT(a_step_frees_input, i_clk, i_rst_n, w_step && !i_in_valid, !r_in_valid, "input register not freed")

endmodule
